/* rtl/core/sorted_key_table_core_assert.svh */
// assertion macros used by the checker file
`ifndef SORTED_KEY_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SKT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sktab_pkg.sv */
package sktab_pkg;

    // default table depth
    localparam int SKT_CAPACITY = 64;

    // field widths
    localparam int KEY_W   = 20;
    localparam int VALUE_W = 20;
    localparam int POS_W   = 7;

    // legal ranges
    localparam logic [KEY_W-1:0]   KEY_LOW    = 20'd100000;
    localparam logic [KEY_W-1:0]   KEY_HIGH   = 20'd999999;
    localparam logic [VALUE_W-1:0] VALUE_LOW  = 20'd1;
    localparam logic [VALUE_W-1:0] VALUE_HIGH = 20'd1000000;

    // function codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BAD_KEY   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4,
        ST_BAD_VALUE = 3'd5
    } t_status;

    // input item
    typedef struct packed {
        logic               func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    // result item
    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] found_value;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   entry_count;
    } t_out_item;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_rec;

endpackage

/* rtl/core/sktab_mem.sv */
module sktab_mem import sktab_pkg::*; #(
    parameter int DEPTH = SKT_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  t_rec                     i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output t_rec                     o_rd_data
);

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/sorted_key_table_core.sv */
// sorted key table: records held in ascending key order in one record memory
// a bad key goes straight to emit; otherwise records are read in order until a key not below
// the item key or the end, and a successful insert shifts the displaced records up one slot
// one item at a time: the input side reopens as the result is registered,
// and a stalled result holds the next item in the emit state
// reset clears the record count and control; memory contents are not cleared
module sorted_key_table_core import sktab_pkg::*; #(
    parameter int CAPACITY = SKT_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_CMP  = 6'b000100,
        S_SHRD = 6'b001000,
        S_SHWR = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_func, n_func;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VALUE_W-1:0] r_value, n_value;
    t_rec               r_carry, n_carry;
    t_status            r_status, n_status;
    logic [VALUE_W-1:0] r_fval, n_fval;
    logic [CW-1:0]      r_pos, n_pos;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data, n_out_data;

    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    t_rec               mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    t_rec               mem_rd_data;

    logic               value_bad;
    logic               table_full;
    t_rec               new_rec;

    sktab_mem #(
        .DEPTH(CAPACITY)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // insert checks on the held item
    assign value_bad  = (r_value < VALUE_LOW) || (r_value > VALUE_HIGH);
    assign table_full = (r_count == CW'(CAPACITY));
    assign new_rec    = '{key: r_key, value: r_value};

    // sequencer: scan, decide, shift up, emit
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_func      = r_func;
        n_key       = r_key;
        n_value     = r_value;
        n_carry     = r_carry;
        n_status    = r_status;
        n_fval      = r_fval;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_idx[AW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_idx[AW-1:0];
        mem_wr_data = r_carry;

        // output register drains on transfer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_in_data.func;
                    n_key   = i_in_data.key;
                    n_value = i_in_data.value;
                    n_idx   = '0;
                    n_fval  = '0;
                    n_pos   = '0;
                    if ((i_in_data.key < KEY_LOW) || (i_in_data.key > KEY_HIGH)) begin
                        n_status = ST_BAD_KEY;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    // every stored key is below the item key
                    n_state = S_EMIT;
                    if (r_func == FUNC_LOOKUP) begin
                        n_status = ST_NOT_FOUND;
                    end else if (value_bad) begin
                        n_status = ST_BAD_VALUE;
                    end else if (table_full) begin
                        n_status = ST_FULL;
                    end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = new_rec;
                        n_count     = r_count + CW'(1);
                        n_pos       = r_idx;
                        n_status    = ST_OK;
                    end
                end else begin
                    mem_rd_en = 1'b1;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (mem_rd_data.key >= r_key) begin
                    n_state = S_EMIT;
                    if (r_func == FUNC_LOOKUP) begin
                        if (mem_rd_data.key == r_key) begin
                            n_status = ST_OK;
                            n_fval   = mem_rd_data.value;
                            n_pos    = r_idx;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end else if (mem_rd_data.key == r_key) begin
                        n_status = ST_DUPLICATE;
                    end else if (value_bad) begin
                        n_status = ST_BAD_VALUE;
                    end else if (table_full) begin
                        n_status = ST_FULL;
                    end else begin
                        // place new record, carry the displaced one upward
                        mem_wr_en   = 1'b1;
                        mem_wr_data = new_rec;
                        n_carry     = mem_rd_data;
                        n_pos       = r_idx;
                        n_idx       = r_idx + CW'(1);
                        n_status    = ST_OK;
                        n_state     = S_SHRD;
                    end
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SHRD: begin
                if (r_idx == r_count) begin
                    // carried record lands in the first free slot
                    mem_wr_en = 1'b1;
                    n_count   = r_count + CW'(1);
                    n_state   = S_EMIT;
                end else begin
                    mem_rd_en = 1'b1;
                    n_state   = S_SHWR;
                end
            end
            S_SHWR: begin
                mem_wr_en = 1'b1;
                n_carry   = mem_rd_data;
                n_idx     = r_idx + CW'(1);
                n_state   = S_SHRD;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_data.status      = r_status;
                    n_out_data.found_value = r_fval;
                    n_out_data.position    = POS_W'(r_pos);
                    n_out_data.entry_count = POS_W'(r_count);
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_func     <= n_func;
        r_key      <= n_key;
        r_value    <= n_value;
        r_carry    <= n_carry;
        r_status   <= n_status;
        r_fval     <= n_fval;
        r_pos      <= n_pos;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/core/sktab_checker.sv */
`include "sorted_key_table_core_assert.svh"

module sktab_checker import sktab_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_data
);

    // stalled result stays offered
    `SKT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid, "result dropped while stalled")

    // stalled result payload holds
    `SKT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_out_data), "result changed while stalled")

    // one item at a time: a transfer closes the input side
    `SKT_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall, "input open right after transfer")

    // only a good outcome carries a value or a position
    `SKT_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, i_out_valid && (i_out_data.status != ST_OK), (i_out_data.found_value == '0) && (i_out_data.position == '0), "failed result carries data")

endmodule

bind sorted_key_table_core sktab_checker u_sktab_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
